// ----- rtl/hrd_pkg.sv -----
`default_nettype none
package hrd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned MinPreW = 5;
    localparam int unsigned StatW   = 2;
    localparam int unsigned AddrW   = 3;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [ByteW-1:0]   Preamble     = 8'hFF;
    localparam logic [ByteW-1:0]   DelimMask    = 8'h07;
    localparam logic [ByteW-1:0]   DelimCode    = 8'h06;
    localparam logic [ByteW-1:0]   DelimShort   = 8'h06;
    localparam logic [ByteW-1:0]   DelimLong    = 8'h86;
    localparam logic [MinPreW-1:0] PreRunMax    = 5'd31;
    localparam logic [AddrW-1:0]   AddrLongLen  = 3'd5;
    localparam logic [AddrW-1:0]   AddrShortLen = 3'd1;

    localparam logic [MinPreW-1:0] MinPreReset  = 5'd2;
    localparam logic               LongReset    = 1'b0;

    localparam logic [CfgIdxW-1:0] CfgExpectLong   = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgMinPreambles = 1'd1;

    typedef enum logic [StatW-1:0] {
        ST_GOOD     = 2'd0,
        ST_CSUM_ERR = 2'd1,
        ST_TYPE_ERR = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_ADDR  = 6'b000010,
        PH_CMD   = 6'b000100,
        PH_COUNT = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CHECK = 6'b100000
    } t_phase;

    typedef struct packed {
        logic               expect_long;
        logic [MinPreW-1:0] min_preambles;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
        logic             last;
        t_status          status;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/hrd_parser.sv -----
`default_nettype none
module hrd_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_beat,
    input  wire logic [hrd_pkg::ByteW-1:0]  i_rx_byte,
    input  wire hrd_pkg::t_cfg              i_cfg,
    output hrd_pkg::t_result                o_result
);

    hrd_pkg::t_phase                r_phase, n_phase;
    logic [hrd_pkg::MinPreW-1:0]    r_pre_run, n_pre_run;
    logic [hrd_pkg::ByteW-1:0]      r_xor, n_xor;
    logic [hrd_pkg::AddrW-1:0]      r_addr_left, n_addr_left;
    logic [hrd_pkg::ByteW-1:0]      r_data_left, n_data_left;
    logic                           r_mismatch, n_mismatch;

    logic [hrd_pkg::ByteW-1:0]      xor_now;
    logic [hrd_pkg::ByteW-1:0]      want;

    assign xor_now = r_xor ^ i_rx_byte;
    assign want    = i_cfg.expect_long ? hrd_pkg::DelimLong : hrd_pkg::DelimShort;

    always_comb begin
        n_phase     = r_phase;
        n_pre_run   = r_pre_run;
        n_xor       = r_xor;
        n_addr_left = r_addr_left;
        n_data_left = r_data_left;
        n_mismatch  = r_mismatch;
        o_result        = '0;
        o_result.data   = i_rx_byte;
        o_result.status = hrd_pkg::ST_GOOD;
        unique case (r_phase)
            hrd_pkg::PH_ADDR: begin
                n_xor       = xor_now;
                n_addr_left = r_addr_left - 1'b1;
                if (n_addr_left == '0) begin
                    n_phase = hrd_pkg::PH_CMD;
                end
            end
            hrd_pkg::PH_CMD: begin
                n_xor          = xor_now;
                n_phase        = hrd_pkg::PH_COUNT;
                o_result.valid = i_beat;
            end
            hrd_pkg::PH_COUNT: begin
                n_xor          = xor_now;
                n_data_left    = i_rx_byte;
                n_phase        = (i_rx_byte != '0) ? hrd_pkg::PH_DATA : hrd_pkg::PH_CHECK;
                o_result.valid = i_beat;
            end
            hrd_pkg::PH_DATA: begin
                n_xor          = xor_now;
                n_data_left    = r_data_left - 1'b1;
                if (n_data_left == '0) begin
                    n_phase = hrd_pkg::PH_CHECK;
                end
                o_result.valid = i_beat;
            end
            hrd_pkg::PH_CHECK: begin
                o_result.valid = i_beat;
                o_result.last  = 1'b1;
                if (xor_now != '0) begin
                    o_result.status = hrd_pkg::ST_CSUM_ERR;
                end else if (r_mismatch) begin
                    o_result.status = hrd_pkg::ST_TYPE_ERR;
                end
                n_phase     = hrd_pkg::PH_HUNT;
                n_pre_run   = '0;
                n_xor       = '0;
                n_addr_left = '0;
                n_data_left = '0;
                n_mismatch  = 1'b0;
            end
            default: begin
                n_phase = hrd_pkg::PH_HUNT;
                if (i_rx_byte == hrd_pkg::Preamble) begin
                    if (r_pre_run < hrd_pkg::PreRunMax) begin
                        n_pre_run = r_pre_run + 1'b1;
                    end
                end else if ((i_rx_byte & hrd_pkg::DelimMask) == hrd_pkg::DelimCode
                             && r_pre_run >= i_cfg.min_preambles) begin
                    n_mismatch  = (i_rx_byte != want);
                    n_xor       = i_rx_byte;
                    n_addr_left = i_rx_byte[hrd_pkg::ByteW-1] ? hrd_pkg::AddrLongLen
                                                              : hrd_pkg::AddrShortLen;
                    n_data_left = '0;
                    n_pre_run   = '0;
                    n_phase     = hrd_pkg::PH_ADDR;
                end else begin
                    n_pre_run = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hrd_pkg::PH_HUNT;
            r_pre_run   <= '0;
            r_xor       <= '0;
            r_addr_left <= '0;
            r_data_left <= '0;
            r_mismatch  <= 1'b0;
        end else if (i_beat) begin
            r_phase     <= n_phase;
            r_pre_run   <= n_pre_run;
            r_xor       <= n_xor;
            r_addr_left <= n_addr_left;
            r_data_left <= n_data_left;
            r_mismatch  <= n_mismatch;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hart_response_deframer_top.sv -----
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_rx_byte
// out       output     o_out_valid / i_out_ready  o_out_byte, o_is_last, o_frame_status
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte per cycle while o_in_ready is high; a byte is parsed in the cycle it is
// taken and its result sits in the output register the next cycle
// o_in_ready drops only while a result is held and the sink is stalled
// synchronous active-low reset puts the parser in the hunt and clears the output valid
// cfg writes are taken every cycle
`default_nettype none
module hart_response_deframer_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_ready,
    input  wire logic [hrd_pkg::ByteW-1:0]    i_rx_byte,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    output      logic [hrd_pkg::ByteW-1:0]    o_out_byte,
    output      logic                         o_is_last,
    output      logic [hrd_pkg::StatW-1:0]    o_frame_status,
    input  wire logic                         i_cfg_valid,
    output      logic                         o_cfg_ready,
    input  wire logic [hrd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [hrd_pkg::MinPreW-1:0]  i_cfg_data
);

    hrd_pkg::t_cfg     r_cfg;
    hrd_pkg::t_result  res;
    logic              r_out_valid;
    logic [hrd_pkg::ByteW-1:0] r_out_byte;
    logic              r_out_last;
    hrd_pkg::t_status  r_out_status;
    logic              in_beat;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_beat     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expect_long   <= hrd_pkg::LongReset;
            r_cfg.min_preambles <= hrd_pkg::MinPreReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hrd_pkg::CfgExpectLong:   r_cfg.expect_long   <= i_cfg_data[0];
                hrd_pkg::CfgMinPreambles: r_cfg.min_preambles <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hrd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (in_beat),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && res.valid) begin
            r_out_byte   <= res.data;
            r_out_last   <= res.last;
            r_out_status <= res.status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_is_last      = r_out_last;
    assign o_frame_status = r_out_status;

endmodule
`default_nettype wire

// ----- rtl/hrd_checker.sv -----
`default_nettype none
module hrd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic [hrd_pkg::ByteW-1:0]    i_rx_byte,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [hrd_pkg::ByteW-1:0]    o_out_byte,
    input wire logic                         o_is_last,
    input wire logic [hrd_pkg::StatW-1:0]    o_frame_status,
    input wire logic                         i_cfg_valid,
    input wire logic                         o_cfg_ready,
    input wire logic [hrd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input wire logic [hrd_pkg::MinPreW-1:0]  i_cfg_data
);

    logic unused;
    assign unused = ^{i_in_valid, i_rx_byte, o_out_byte, i_cfg_valid, o_cfg_ready,
                      i_cfg_index, i_cfg_data};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("out beat dropped while stalled");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result stalled");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_frame_status == hrd_pkg::ST_GOOD)
        else $error("status set on non-last beat");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_status != 2'd3)
        else $error("bad frame status");

endmodule

bind hart_response_deframer_top hrd_checker u_hrd_checker (.*);
`default_nettype wire

// ----- tb/sv/hrd_frame_checker.sv -----
`timescale 1ns / 1ps
module hrd_frame_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [hrd_pkg::ByteW-1:0]   i_rx_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [hrd_pkg::ByteW-1:0]   i_out_byte,
    input  logic                        i_is_last,
    input  logic [hrd_pkg::StatW-1:0]   i_frame_status,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [hrd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [hrd_pkg::MinPreW-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import hrd_pkg::*;

    logic               long_frames;
    logic [MinPreW-1:0] min_pre;

    t_phase             phase;
    logic [MinPreW-1:0] pre_run;
    logic [ByteW-1:0]   frame_xor;
    logic [AddrW-1:0]   addr_left;
    logic [ByteW-1:0]   data_left;
    logic               delim_wrong;

    t_result            frame_beats[$];
    t_result            want;
    t_result            next_beat;
    int                 fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_frame();
        phase       = PH_HUNT;
        pre_run     = '0;
        frame_xor   = '0;
        addr_left   = '0;
        data_left   = '0;
        delim_wrong = 1'b0;
    endfunction

    function automatic t_result deframe_byte(input logic [ByteW-1:0] b);
        t_result          r;
        logic [ByteW-1:0] sum;
        r.valid  = 1'b0;
        r.data   = b;
        r.last   = 1'b0;
        r.status = ST_GOOD;
        case (phase)
            PH_ADDR: begin
                frame_xor = frame_xor ^ b;
                addr_left = addr_left - 1'b1;
                if (addr_left == '0) begin
                    phase = PH_CMD;
                end
            end
            PH_CMD: begin
                frame_xor = frame_xor ^ b;
                phase     = PH_COUNT;
                r.valid   = 1'b1;
            end
            PH_COUNT: begin
                frame_xor = frame_xor ^ b;
                data_left = b;
                phase     = (b != '0) ? PH_DATA : PH_CHECK;
                r.valid   = 1'b1;
            end
            PH_DATA: begin
                frame_xor = frame_xor ^ b;
                data_left = data_left - 1'b1;
                if (data_left == '0) begin
                    phase = PH_CHECK;
                end
                r.valid = 1'b1;
            end
            PH_CHECK: begin
                sum     = frame_xor ^ b;
                r.valid = 1'b1;
                r.last  = 1'b1;
                if (sum != '0) begin
                    r.status = ST_CSUM_ERR;
                end else if (delim_wrong) begin
                    r.status = ST_TYPE_ERR;
                end
                clear_frame();
            end
            default: begin
                if (b == Preamble) begin
                    if (pre_run != PreRunMax) begin
                        pre_run = pre_run + 1'b1;
                    end
                end else if ((b & DelimMask) == DelimCode && pre_run >= min_pre) begin
                    delim_wrong = (b != (long_frames ? DelimLong : DelimShort));
                    frame_xor   = b;
                    addr_left   = b[7] ? AddrLongLen : AddrShortLen;
                    data_left   = '0;
                    pre_run     = '0;
                    phase       = PH_ADDR;
                end else begin
                    pre_run = '0;
                    phase   = PH_HUNT;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_frames = LongReset;
            min_pre     = MinPreReset;
            clear_frame();
            frame_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CfgExpectLong:   long_frames = i_cfg_data[0];
                    CfgMinPreambles: min_pre = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_beats.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected beat, expected none, actual byte %h last %b status %0d",
                             $realtime, i_out_byte, i_is_last, i_frame_status);
                end else begin
                    want = frame_beats.pop_front();
                    if (i_out_byte !== want.data || i_is_last !== want.last ||
                        i_frame_status !== want.status) begin
                        fails++;
                    end
                    if (i_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $realtime, want.data, i_out_byte);
                    end
                    if (i_is_last !== want.last) begin
                        $display("%0t: is_last expected %b actual %b",
                                 $realtime, want.last, i_is_last);
                    end
                    if (i_frame_status !== want.status) begin
                        $display("%0t: frame_status expected %0d actual %0d",
                                 $realtime, want.status, i_frame_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                next_beat = deframe_byte(i_rx_byte);
                if (next_beat.valid) begin
                    frame_beats.push_back(next_beat);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= frame_beats.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import hrd_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [ByteW-1:0]   rx_byte = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [MinPreW-1:0] cfg_data = '0;

    logic               in_ready;
    logic               out_valid;
    logic [ByteW-1:0]   out_byte;
    logic               is_last;
    logic [StatW-1:0]   frame_status;
    logic               cfg_ready;

    int                 fail_count;
    int                 pending;
    int                 bytes_sent = 0;
    bit                 calm = 1'b0;
    bit                 cur_long = LongReset;
    logic [MinPreW-1:0] cur_min = MinPreReset;

    bit                 phase_long[6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [MinPreW-1:0] phase_min[6]  = '{5'd1, 5'd31, 5'd0, 5'd5, 5'd3, 5'd31};

    hart_response_deframer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_out_byte     (out_byte),
        .o_is_last      (is_last),
        .o_frame_status (frame_status),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    hrd_frame_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_byte     (out_byte),
        .i_is_last      (is_last),
        .i_frame_status (frame_status),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_byte(input logic [ByteW-1:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [ByteW-1:0] delim, input int npre,
                              input int count, input bit bad_sum);
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] b;
        repeat (npre) send_byte(Preamble);
        sum = delim;
        send_byte(delim);
        repeat (delim[7] ? 5 : 1) begin
            b = ByteW'($urandom);
            sum ^= b;
            send_byte(b);
        end
        b = ByteW'($urandom);
        sum ^= b;
        send_byte(b);
        b = count[ByteW-1:0];
        sum ^= b;
        send_byte(b);
        repeat (count) begin
            b = ByteW'($urandom);
            sum ^= b;
            send_byte(b);
        end
        if (bad_sum) begin
            sum ^= ByteW'($urandom_range(1, 255));
        end
        send_byte(sum);
    endtask

    // let the parser run dry before touching the registers
    task automatic settle();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending != 0 && guard < 20000);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input bit long_frames, input logic [MinPreW-1:0] min_pre);
        cfg_valid <= 1'b1;
        cfg_index <= CfgExpectLong;
        cfg_data  <= MinPreW'(long_frames);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= CfgMinPreambles;
        cfg_data  <= min_pre;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_long = long_frames;
        cur_min  = min_pre;
    endtask

    task automatic random_traffic(input int budget);
        int               stop_at;
        int               pick;
        int               npre;
        int               count;
        logic [ByteW-1:0] delim;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                if ($urandom_range(0, 4) == 0) begin
                    delim      = ByteW'($urandom);
                    delim[2:0] = 3'b110;
                end else begin
                    delim = cur_long ? DelimLong : DelimShort;
                end
                case ($urandom_range(0, 15))
                    0, 1:    npre = $urandom_range(0, cur_min);
                    2:       npre = 35;
                    default: npre = cur_min + $urandom_range(0, 3);
                endcase
                count = ($urandom_range(0, 63) == 0) ? $urandom_range(200, 255)
                                                     : $urandom_range(0, 6);
                send_frame(delim, npre, count, $urandom_range(0, 4) == 0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 8)) send_byte(ByteW'($urandom));
            end else begin
                // preamble and delimiter, then the frame breaks off
                repeat (cur_min + 1) send_byte(Preamble);
                send_byte(cur_long ? DelimLong : DelimShort);
                repeat ($urandom_range(0, 3)) send_byte(ByteW'($urandom));
            end
        end
    endtask

    always begin
        int stall;
        stall = draw_wait();
        if (stall > 0) begin
            out_ready <= 1'b0;
            repeat (stall) @(posedge i_clk);
        end
        out_ready <= 1'b1;
        do @(posedge i_clk); while (!out_valid);
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(DelimShort, 2, 0, 1'b0);
        send_frame(DelimLong, 3, 1, 1'b0);
        send_frame(DelimLong, 2, 2, 1'b1);
        send_frame(DelimShort, 2, 1, 1'b1);
        send_byte(Preamble);
        send_byte(DelimShort);
        send_byte(8'h00);
        random_traffic(120);
        settle();

        for (int p = 0; p < 6; p++) begin
            write_config(phase_long[p], phase_min[p]);
            random_traffic(130);
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hrd_pkg.sv
rtl/hrd_parser.sv
rtl/hart_response_deframer_top.sv
rtl/hrd_checker.sv
tb/sv/hrd_frame_checker.sv
tb/sv/tb_top.sv
